/* design/dsg_pkg.sv */
package dsg_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ENV_W    = 31;
  localparam int unsigned LEN_W    = 21;
  localparam int unsigned POS_W    = 20;
  localparam int unsigned OPND_W   = 33;
  localparam int unsigned PROD_W   = 2 * OPND_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned POS_LIMIT = 1 << POS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OSC_COEFF      = 3'd0,
    REG_START_LAST     = 3'd1,
    REG_START_OLDER    = 3'd2,
    REG_DECAY_FACTOR   = 3'd3,
    REG_START_ENVELOPE = 3'd4,
    REG_RING_LENGTH    = 3'd5,
    REG_TOTAL_LENGTH   = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_OSC,
    ST_MUL_DECAY,
    ST_MUL_SAMPLE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_OSC,
    MUL_DECAY,
    MUL_SAMPLE
  } mul_sel_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] osc_coeff;
    logic signed [DATA_W-1:0] start_last;
    logic signed [DATA_W-1:0] start_older;
    logic [ENV_W-1:0]         decay_factor;
    logic [ENV_W-1:0]         start_envelope;
    logic [LEN_W-1:0]         ring_length;
    logic [LEN_W-1:0]         total_length;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     nxt_en;
    logic     upd_en;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

/* design/damped_sinusoid_generator.sv */
// path: an input is taken only in idle; the single shared 33x33 multiplier
//   then runs three products per sample (oscillator, envelope decay, sample
//   scaling), one per state, before emit waits for a free output register
// reset: rst_n synchronous active low; config registers return to defaults
//   and the oscillator state to the default start values
module damped_sinusoid_generator #(
  parameter int unsigned MAX_LEN   = 1048576,
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsg_pkg::DATA_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dsg_pkg::DATA_W-1:0]   out_sample,
  output logic [dsg_pkg::POS_W-1:0]           out_sample_index,
  output logic                                out_last
);
  import dsg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  dsg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dsg_dp #(
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_sample_index (out_sample_index),
    .out_last         (out_last)
  );

endmodule

/* design/dsg_regs.sv */
module dsg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsg_pkg::DATA_W-1:0]       cfg_wdata,
  output dsg_pkg::cfg_t                    cfg
);
  import dsg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_OSC_COEFF:      cfg_nxt.osc_coeff      = cfg_wdata;
        REG_START_LAST:     cfg_nxt.start_last     = cfg_wdata;
        REG_START_OLDER:    cfg_nxt.start_older    = cfg_wdata;
        REG_DECAY_FACTOR:   cfg_nxt.decay_factor   = cfg_wdata[ENV_W-1:0];
        REG_START_ENVELOPE: cfg_nxt.start_envelope = cfg_wdata[ENV_W-1:0];
        REG_RING_LENGTH:    cfg_nxt.ring_length    = cfg_wdata[LEN_W-1:0];
        REG_TOTAL_LENGTH:   cfg_nxt.total_length   = cfg_wdata[LEN_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.osc_coeff      <= '0;
      cfg_r.start_last     <= '0;
      cfg_r.start_older    <= '0;
      cfg_r.decay_factor   <= ENV_W'(32'h4000_0000);
      cfg_r.start_envelope <= ENV_W'(32'h4000_0000);
      cfg_r.ring_length    <= '0;
      cfg_r.total_length   <= LEN_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/dsg_ctrl.sv */
module dsg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dsg_pkg::status_t  status,
  output dsg_pkg::cmd_t     cmd
);
  import dsg_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_MUL_OSC;
      ST_MUL_OSC:    state_nxt = ST_MUL_DECAY;
      ST_MUL_DECAY:  state_nxt = ST_MUL_SAMPLE;
      ST_MUL_SAMPLE: state_nxt = ST_EMIT;
      ST_EMIT:       if (status.out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_MUL_OSC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_OSC;
      end
      ST_MUL_DECAY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DECAY;
        cmd.nxt_en  = 1'b1;
      end
      ST_MUL_SAMPLE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SAMPLE;
        cmd.upd_en  = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* design/dsg_dp.sv */
module dsg_dp #(
  parameter int unsigned MAX_LEN   = 1048576,
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dsg_pkg::cfg_t                       cfg,
  input  dsg_pkg::cmd_t                       cmd,
  output dsg_pkg::status_t                    status,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dsg_pkg::DATA_W-1:0]   out_sample,
  output logic [dsg_pkg::POS_W-1:0]           out_sample_index,
  output logic                                out_last
);
  import dsg_pkg::*;

  localparam int unsigned LenCapInt = (MAX_LEN < POS_LIMIT) ? MAX_LEN : POS_LIMIT;
  localparam logic [LEN_W-1:0] LenCap = LEN_W'(LenCapInt);
  localparam logic signed [PROD_W-1:0] Half =
    $signed({{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));

  logic signed [DATA_W-1:0] last_r;
  logic signed [DATA_W-1:0] older_r;
  logic [ENV_W-1:0]         env_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] nxt_r;
  logic signed [PROD_W-1:0] prod_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_sample_r;
  logic [POS_W-1:0]         out_index_r;
  logic                     out_last_r;

  logic signed [OPND_W-1:0] mul_a;
  logic signed [OPND_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W:0]   osc_diff;
  logic signed [DATA_W-1:0] osc_sat;
  logic signed [DATA_W-1:0] smp_sat;
  logic [ENV_W-1:0]         env_sat;
  logic [LEN_W-1:0]         total_eff;
  logic                     active;
  logic                     is_last;
  logic                     reload;

  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [PROD_W:0] v);
    logic fits;
    fits = (v[PROD_W:DATA_W-1] == '0) || (v[PROD_W:DATA_W-1] == '1);
    if (fits) begin
      sat_s32 = v[DATA_W-1:0];
    end else if (v[PROD_W]) begin
      sat_s32 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_s32 = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    case (cmd.mul_sel)
      MUL_OSC: begin
        mul_a = {cfg.osc_coeff[DATA_W-1], cfg.osc_coeff};
        mul_b = {last_r[DATA_W-1], last_r};
      end
      MUL_DECAY: begin
        mul_a = $signed({2'b00, env_r});
        mul_b = $signed({2'b00, cfg.decay_factor});
      end
      MUL_SAMPLE: begin
        mul_a = $signed({2'b00, env_r});
        mul_b = {nxt_r[DATA_W-1], nxt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round half up, floor shift
  assign rnd      = (prod_r + Half) >>> FRAC_BITS;
  assign osc_diff = {rnd[PROD_W-1], rnd} -
                    {{(PROD_W+1-DATA_W){older_r[DATA_W-1]}}, older_r};
  assign osc_sat  = sat_s32(osc_diff);
  assign smp_sat  = sat_s32({rnd[PROD_W-1], rnd});
  assign env_sat  = (rnd[PROD_W-1:ENV_W] == '0) ? rnd[ENV_W-1:0] : '1;

  always_comb begin
    if (cfg.total_length == '0) begin
      total_eff = LEN_W'(1);
    end else if (cfg.total_length > LenCap) begin
      total_eff = LenCap;
    end else begin
      total_eff = cfg.total_length;
    end
  end

  assign active  = {1'b0, pos_r} < cfg.ring_length;
  assign is_last = ({1'b0, pos_r} + LEN_W'(1)) >= total_eff;
  assign reload  = (cmd.accept && in_restart) || (cmd.emit && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      older_r <= '0;
      env_r   <= ENV_W'(32'h4000_0000);
      pos_r   <= '0;
    end else if (reload) begin
      last_r  <= cfg.start_last;
      older_r <= cfg.start_older;
      env_r   <= cfg.start_envelope;
      pos_r   <= '0;
    end else begin
      if (cmd.upd_en && active) begin
        env_r   <= env_sat;
        last_r  <= nxt_r;
        older_r <= last_r;
      end
      if (cmd.emit) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
    if (cmd.nxt_en) begin
      nxt_r <= osc_sat;
    end
  end

  // output register, loaded only when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= active ? smp_sat : '0;
      out_index_r  <= pos_r;
      out_last_r   <= is_last;
    end
  end

  assign status.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_sample_index = out_index_r;
  assign out_last         = out_last_r;

endmodule
